[rtl/core/rvx_pkg.sv]
package rvx_pkg;

   localparam logic [4:0] OP_NOP     = 5'd0;
   localparam logic [4:0] OP_MOV     = 5'd1;
   localparam logic [4:0] OP_PSH     = 5'd2;
   localparam logic [4:0] OP_POP     = 5'd3;
   localparam logic [4:0] OP_ADD     = 5'd4;
   localparam logic [4:0] OP_SUB     = 5'd5;
   localparam logic [4:0] OP_MUL     = 5'd6;
   localparam logic [4:0] OP_DIV     = 5'd7;
   localparam logic [4:0] OP_MOD     = 5'd8;
   localparam logic [4:0] OP_INC     = 5'd9;
   localparam logic [4:0] OP_DEC     = 5'd10;
   localparam logic [4:0] OP_CLF     = 5'd11;
   localparam logic [4:0] OP_CMP     = 5'd12;
   localparam logic [4:0] OP_JMP     = 5'd13;
   localparam logic [4:0] OP_JEQ     = 5'd14;
   localparam logic [4:0] OP_JNE     = 5'd15;
   localparam logic [4:0] OP_JLE     = 5'd16;
   localparam logic [4:0] OP_JLT     = 5'd17;
   localparam logic [4:0] OP_JGE     = 5'd18;
   localparam logic [4:0] OP_JGT     = 5'd19;
   localparam logic [4:0] OP_AND     = 5'd20;
   localparam logic [4:0] OP_BOR     = 5'd21;
   localparam logic [4:0] OP_XOR     = 5'd22;
   localparam logic [4:0] OP_NOT     = 5'd23;
   localparam logic [4:0] OP_SHR     = 5'd24;
   localparam logic [4:0] OP_SHL     = 5'd25;
   localparam logic [4:0] OP_CALL    = 5'd26;
   localparam logic [4:0] OP_RET     = 5'd27;
   localparam logic [4:0] OP_SYSCALL = 5'd28;
   localparam logic [4:0] OP_HLT     = 5'd29;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DIV0    = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_BADADDR = 3'd3;
   localparam logic [2:0] ST_STACK   = 3'd4;

   localparam logic [1:0] MODE_REG = 2'd0;
   localparam logic [1:0] MODE_MEM = 2'd1;
   localparam logic [1:0] MODE_IMM = 2'd2;

   localparam logic [2:0] FLAG_EQ = 3'b001;
   localparam logic [2:0] FLAG_LT = 3'b010;
   localparam logic [2:0] FLAG_GT = 3'b100;

   typedef struct packed {
      logic [4:0]         kind;
      logic [1:0]         src_mode;
      logic [1:0]         dst_mode;
      logic signed [63:0] src_operand;
      logic [15:0]        dst_operand;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        halted;
      logic [2:0]  status;
   } rsp_type;

endpackage

[rtl/core/register_vm_execute_unit.sv]
// Executes one decoded VM instruction per request word and returns one response word
// with the next PC, a halt mark and a status code. After reset the unit first clears
// the data memory, one word per cycle, and takes no request meanwhile. Most
// instructions then pass through source read, destination read, execute and write
// back; the response is registered out of write back, which waits while an earlier
// response is still stalled, and no new request is taken until the unit is idle. An
// address or stack fault found at decode skips from source read straight to write
// back. MUL, DIV and MOD run 64 shift-add or restoring-divide steps on a single
// 65-bit adder, then DIV and MOD fix the sign; a zero divisor skips the steps.
// One instruction is in flight at a time; the response register lets the next request
// be accepted while a response still waits.
module register_vm_execute_unit #(
   parameter int REG_COUNT   = 8,
   parameter int STACK_DEPTH = 64,
   parameter int MEM_WORDS   = 4096,
   parameter int PC_WIDTH    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rvx_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rvx_pkg::rsp_type  rsp_data
);

   localparam int REG_AW = $clog2(REG_COUNT);
   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_SRC   = 9'b000000100,
      S_DST   = 9'b000001000,
      S_EXEC  = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_DFIX  = 9'b010000000,
      S_WB    = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   rvx_pkg::req_type    req_ff, req_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [2:0]          flags_ff, flags_in;
   logic [2:0]          st_ff, st_in;
   logic [2:0]          cmp_ff, cmp_in;
   logic [63:0]         src_ff, src_in;
   logic [63:0]         opa_ff, opa_in;
   logic [63:0]         opb_ff, opb_in;
   logic [63:0]         rem_ff, rem_in;
   logic [63:0]         res_ff, res_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                nega_ff, nega_in;
   logic                negb_ff, negb_in;
   logic [MEM_AW-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rvx_pkg::rsp_type    rsp_ff, rsp_in;

   logic [63:0]         reg_mem [REG_COUNT];
   logic                reg_vld_ff [REG_COUNT];
   logic [63:0]         data_mem [MEM_WORDS];
   logic [63:0]         stk_mem [STACK_DEPTH];
   logic [63:0]         reg_rd_ff, mem_rd_ff, stk_rd_ff;

   logic [15:0]         raddr;
   logic                reg_we, mem_we, stk_we;
   logic [MEM_AW-1:0]   mem_waddr;
   logic [63:0]         mem_wdata;
   logic [SP_W-1:0]     sp_dec;

   logic [4:0]          kind;
   logic [1:0]          sm, dm;
   logic [63:0]         so;
   logic [15:0]         dop;
   logic [31:0]         dop_ext;
   logic [PC_WIDTH-1:0] tgt;
   logic [31:0]         pc_ext;
   logic                so_reg_ok, so_mem_ok, dop_reg_ok, dop_mem_ok;
   logic                src_bad, dst_bad, full, empty;
   logic                is_arith, is_bit, is_incdec, d_reg, psh_cell, push_en;
   logic                jump_tk, ok, wr_cell;
   logic [2:0]          chk;
   logic [63:0]         dv, sh_r, sh_l, rem_sh, fix_v;
   logic                fix_neg;
   logic [63:0]         add_x, add_y;
   logic                add_ci;
   logic [64:0]         sum;

   always_comb begin
      kind       = req_ff.kind;
      sm         = req_ff.src_mode;
      dm         = req_ff.dst_mode;
      so         = req_ff.src_operand;
      dop        = req_ff.dst_operand;
      dop_ext    = {16'd0, dop};
      tgt        = dop_ext[PC_WIDTH-1:0];
      so_reg_ok  = so < 64'(REG_COUNT);
      so_mem_ok  = so < 64'(MEM_WORDS);
      dop_reg_ok = {1'b0, dop} < 17'(REG_COUNT);
      dop_mem_ok = {1'b0, dop} < 17'(MEM_WORDS);
      src_bad    = (sm == rvx_pkg::MODE_REG && !so_reg_ok) ||
                   (sm == rvx_pkg::MODE_MEM && !so_mem_ok);
      full       = sp_ff == SP_W'(STACK_DEPTH);
      empty      = sp_ff == '0;
      sp_dec     = sp_ff - SP_W'(1);
      is_arith   = (kind >= rvx_pkg::OP_ADD && kind <= rvx_pkg::OP_MOD) ||
                   kind == rvx_pkg::OP_CMP;
      is_bit     = kind >= rvx_pkg::OP_AND && kind <= rvx_pkg::OP_SHL;
      is_incdec  = kind == rvx_pkg::OP_INC || kind == rvx_pkg::OP_DEC;
      d_reg      = is_bit || kind == rvx_pkg::OP_POP ||
                   (is_incdec ? (sm != rvx_pkg::MODE_MEM) : (dm == rvx_pkg::MODE_REG));
      dst_bad    = d_reg ? !dop_reg_ok : !dop_mem_ok;
      psh_cell   = dm == rvx_pkg::MODE_REG || dm == rvx_pkg::MODE_MEM;
      push_en    = kind == rvx_pkg::OP_PSH && (psh_cell || sm == rvx_pkg::MODE_IMM);

      chk     = rvx_pkg::ST_OK;
      jump_tk = 1'b0;
      case (kind)
         rvx_pkg::OP_NOP, rvx_pkg::OP_SYSCALL, rvx_pkg::OP_CLF, rvx_pkg::OP_HLT: begin
            chk = rvx_pkg::ST_OK;
         end
         rvx_pkg::OP_MOV: begin
            if (psh_cell && (src_bad || dst_bad)) chk = rvx_pkg::ST_BADADDR;
         end
         rvx_pkg::OP_PSH: begin
            if (psh_cell && dst_bad) chk = rvx_pkg::ST_BADADDR;
            else if (push_en && full) chk = rvx_pkg::ST_STACK;
         end
         rvx_pkg::OP_POP: begin
            if (dst_bad) chk = rvx_pkg::ST_BADADDR;
            else if (empty) chk = rvx_pkg::ST_STACK;
         end
         rvx_pkg::OP_ADD, rvx_pkg::OP_SUB, rvx_pkg::OP_MUL, rvx_pkg::OP_DIV,
         rvx_pkg::OP_MOD, rvx_pkg::OP_CMP: begin
            if (src_bad || dst_bad) chk = rvx_pkg::ST_BADADDR;
         end
         rvx_pkg::OP_INC, rvx_pkg::OP_DEC: begin
            if (dst_bad) chk = rvx_pkg::ST_BADADDR;
         end
         rvx_pkg::OP_AND, rvx_pkg::OP_BOR, rvx_pkg::OP_XOR, rvx_pkg::OP_NOT,
         rvx_pkg::OP_SHR, rvx_pkg::OP_SHL: begin
            if (dst_bad || !so_reg_ok) chk = rvx_pkg::ST_BADADDR;
         end
         rvx_pkg::OP_JMP: jump_tk = 1'b1;
         rvx_pkg::OP_JEQ: jump_tk = flags_ff[0];
         rvx_pkg::OP_JNE: jump_tk = !flags_ff[0];
         rvx_pkg::OP_JLE: jump_tk = flags_ff[0] || flags_ff[1];
         rvx_pkg::OP_JLT: jump_tk = !flags_ff[0] && flags_ff[1];
         rvx_pkg::OP_JGE: jump_tk = flags_ff[0] || flags_ff[2];
         rvx_pkg::OP_JGT: jump_tk = !flags_ff[0] && flags_ff[2];
         rvx_pkg::OP_CALL: begin
            if (full) chk = rvx_pkg::ST_STACK;
         end
         rvx_pkg::OP_RET: begin
            if (empty) chk = rvx_pkg::ST_STACK;
         end
         default: chk = rvx_pkg::ST_UNKNOWN;
      endcase

      dv      = d_reg ? reg_rd_ff : mem_rd_ff;
      sh_r    = (|src_ff[63:6]) ? {64{dv[63]}} : 64'($signed(dv) >>> src_ff[5:0]);
      sh_l    = (|src_ff[63:6]) ? 64'd0 : (dv << src_ff[5:0]);
      rem_sh  = {rem_ff[62:0], opa_ff[63]};
      fix_v   = (kind == rvx_pkg::OP_DIV) ? opa_ff : rem_ff;
      fix_neg = (kind == rvx_pkg::OP_DIV) ? (nega_ff ^ negb_ff) : nega_ff;

      // shared adder
      add_x  = dv;
      add_y  = src_ff;
      add_ci = 1'b0;
      case (state_ff)
         S_EXEC: begin
            case (kind)
               rvx_pkg::OP_SUB: begin
                  add_y  = ~src_ff;
                  add_ci = 1'b1;
               end
               rvx_pkg::OP_INC: begin
                  add_y  = 64'd0;
                  add_ci = 1'b1;
               end
               rvx_pkg::OP_DEC: add_y = '1;
               default: add_y = src_ff;
            endcase
         end
         S_MUL: begin
            add_x = rem_ff;
            add_y = opa_ff;
         end
         S_DIV: begin
            add_x  = rem_sh;
            add_y  = ~opb_ff;
            add_ci = 1'b1;
         end
         S_DFIX: begin
            add_x  = 64'd0;
            add_y  = ~fix_v;
            add_ci = 1'b1;
         end
         default: add_ci = 1'b0;
      endcase
      sum = {1'b0, add_x} + {1'b0, add_y} + 65'(add_ci);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      flags_in     = flags_ff;
      st_in        = st_ff;
      cmp_in       = cmp_ff;
      src_in       = src_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      cnt_in       = cnt_ff;
      nega_in      = nega_ff;
      negb_in      = negb_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      raddr        = dop;
      reg_we       = 1'b0;
      mem_we       = 1'b0;
      stk_we       = 1'b0;
      mem_waddr    = dop[MEM_AW-1:0];
      mem_wdata    = res_ff;
      ok           = st_ff == rvx_pkg::ST_OK;
      wr_cell      = ok && ((kind == rvx_pkg::OP_MOV && psh_cell) ||
                     kind == rvx_pkg::OP_POP || (is_arith && kind != rvx_pkg::OP_CMP) ||
                     is_incdec || is_bit);
      pc_ext       = 32'(pc_ff);

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 64'd0;
            clr_in    = clr_ff + MEM_AW'(1);
            if (clr_ff == MEM_AW'(MEM_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               pc_in    = pc_ff + PC_WIDTH'(1);
               state_in = S_SRC;
            end
         end
         S_SRC: begin
            raddr = so[15:0];
            st_in = chk;
            state_in = (chk == rvx_pkg::ST_OK) ? S_DST : S_WB;
         end
         S_DST: begin
            if (is_bit || sm == rvx_pkg::MODE_REG) src_in = reg_rd_ff;
            else if (sm == rvx_pkg::MODE_MEM) src_in = mem_rd_ff;
            else src_in = so;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_WB;
            res_in   = sum[63:0];
            case (kind)
               rvx_pkg::OP_MOV:  res_in = src_ff;
               rvx_pkg::OP_PSH:  res_in = psh_cell ? dv : so;
               rvx_pkg::OP_POP, rvx_pkg::OP_RET: res_in = stk_rd_ff;
               rvx_pkg::OP_CALL: res_in = 64'(pc_ff);
               rvx_pkg::OP_AND:  res_in = dv & src_ff;
               rvx_pkg::OP_BOR:  res_in = dv | src_ff;
               rvx_pkg::OP_XOR:  res_in = dv ^ src_ff;
               rvx_pkg::OP_NOT:  res_in = ~src_ff;
               rvx_pkg::OP_SHR:  res_in = sh_r;
               rvx_pkg::OP_SHL:  res_in = sh_l;
               rvx_pkg::OP_CMP: begin
                  if (dv == src_ff) cmp_in = rvx_pkg::FLAG_EQ;
                  else if ($signed(dv) < $signed(src_ff)) cmp_in = rvx_pkg::FLAG_LT;
                  else cmp_in = rvx_pkg::FLAG_GT;
               end
               rvx_pkg::OP_MUL: begin
                  opa_in   = dv;
                  opb_in   = src_ff;
                  rem_in   = 64'd0;
                  cnt_in   = 6'd0;
                  state_in = S_MUL;
               end
               rvx_pkg::OP_DIV, rvx_pkg::OP_MOD: begin
                  if (src_ff == 64'd0) begin
                     st_in = rvx_pkg::ST_DIV0;
                  end else begin
                     nega_in  = dv[63];
                     negb_in  = src_ff[63];
                     opa_in   = dv[63] ? (64'd0 - dv) : dv;
                     opb_in   = src_ff[63] ? (64'd0 - src_ff) : src_ff;
                     rem_in   = 64'd0;
                     cnt_in   = 6'd0;
                     state_in = S_DIV;
                  end
               end
               default: res_in = sum[63:0];
            endcase
         end
         S_MUL: begin
            if (opb_ff[0]) rem_in = sum[63:0];
            opa_in = {opa_ff[62:0], 1'b0};
            opb_in = {1'b0, opb_ff[63:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_DFIX;
         end
         S_DIV: begin
            rem_in = sum[64] ? sum[63:0] : rem_sh;
            opa_in = {opa_ff[62:0], sum[64]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = S_DFIX;
         end
         S_DFIX: begin
            if (kind == rvx_pkg::OP_MUL) res_in = rem_ff;
            else res_in = fix_neg ? sum[63:0] : fix_v;
            state_in = S_WB;
         end
         S_WB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               reg_we = wr_cell && d_reg;
               mem_we = wr_cell && !d_reg;
               stk_we = ok && (push_en || kind == rvx_pkg::OP_CALL);
               if (stk_we) sp_in = sp_ff + SP_W'(1);
               if (ok && (kind == rvx_pkg::OP_POP || kind == rvx_pkg::OP_RET)) sp_in = sp_dec;
               if (ok && (jump_tk || kind == rvx_pkg::OP_CALL)) pc_in = tgt;
               if (ok && kind == rvx_pkg::OP_RET) pc_in = res_ff[PC_WIDTH-1:0];
               if (ok && kind == rvx_pkg::OP_CMP) flags_in = cmp_ff;
               if (ok && kind == rvx_pkg::OP_CLF) flags_in = 3'd0;
               pc_ext         = 32'(pc_in);
               rsp_in.next_pc = pc_ext[15:0];
               rsp_in.halted  = !ok || kind == rvx_pkg::OP_HLT;
               rsp_in.status  = st_ff;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= '0;
         sp_ff        <= '0;
         flags_ff     <= '0;
         st_ff        <= rvx_pkg::ST_OK;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) reg_vld_ff[i] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         flags_ff     <= flags_in;
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) reg_vld_ff[dop[REG_AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      cmp_ff  <= cmp_in;
      src_ff  <= src_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      nega_ff <= nega_in;
      negb_ff <= negb_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reg_we) reg_mem[dop[REG_AW-1:0]] <= res_ff;
      reg_rd_ff <= reg_vld_ff[raddr[REG_AW-1:0]] ? reg_mem[raddr[REG_AW-1:0]] : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) data_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= data_mem[raddr[MEM_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[sp_ff[STK_AW-1:0]] <= res_ff;
      stk_rd_ff <= stk_mem[sp_dec[STK_AW-1:0]];
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
